### sv/vrrf_pkg.sv
// Package for the record range filter and part splitter.
// Holds the event, configuration and result codes shared by the front, the back and the top level.
// No dependencies.
package vrrf_pkg;

  // Characters of interest in the text stream.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_HASH    = 8'd35;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  // Largest position value that can still take another digit without overflow.
  localparam logic [63:0] POS_TENTH = 64'd1844674407370955161;

  // Shift that turns megabytes into bytes.
  localparam int MIB_SHIFT = 20;

  // Configuration register indexes.
  localparam logic [2:0] REG_CHROM_LENGTH = 3'd0;
  localparam logic [2:0] REG_CHROM_NAME   = 3'd1;
  localparam logic [2:0] REG_POS_BEGIN    = 3'd2;
  localparam logic [2:0] REG_POS_END      = 3'd3;
  localparam logic [2:0] REG_LINES_PART   = 3'd4;
  localparam logic [2:0] REG_MB_PART      = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_KEPT     = 3'd1;
  localparam logic [2:0] KIND_SKIPPED  = 3'd2;
  localparam logic [2:0] KIND_CLOSE    = 3'd3;
  localparam logic [2:0] KIND_END_HDR  = 3'd4;

  // Events passed from the front to the back.
  typedef enum logic [1:0] {
    EV_HEADER,
    EV_DATA,
    EV_END_HDR,
    EV_END
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    logic     keep;
    logic     at_end;
  } ev_t;

  // Configuration registers.
  typedef struct packed {
    logic [3:0]  chrom_length;
    logic [63:0] chrom_name;
    logic [63:0] pos_begin;
    logic [63:0] pos_end;
    logic [30:0] lines_per_part;
    logic [30:0] megabytes_per_part;
  } cfg_t;

endpackage

### sv/vrrf_if.sv
// Channel interfaces for the record range filter and part splitter.
// Input byte channel, result channel and configuration write channel.
// No dependencies.
interface vrrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;
  modport source (output valid, text_byte, stream_end, input ready);
  modport sink (input valid, text_byte, stream_end, output ready);
endinterface

interface vrrf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  line_kind;
  logic [31:0] line_length;
  logic [31:0] part_number;
  logic        part_last;
  logic [30:0] part_line_total;
  logic [51:0] part_byte_total;
  modport source (output valid, line_kind, line_length, part_number, part_last,
                  part_line_total, part_byte_total, input ready);
  modport sink (input valid, line_kind, line_length, part_number, part_last,
                part_line_total, part_byte_total, output ready);
endinterface

interface vrrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/vcf_record_range_filter_splitter_core.sv
// Top level of the record range filter and part splitter.
// Holds the configuration registers and joins front, event queue and back.
// Depends on vrrf_pkg, the channel interfaces, vrrf_front, vrrf_fifo, vrrf_back.
//
// Usage: text bytes enter one per transfer on byte_in; stream_end marks the
// end of the stream and carries no byte. Each finished line gives one result
// on result_out: a header line, a kept line or a skipped line, with its
// length and the running totals of the current part. At stream end a
// pending part is closed, or an end inside the header is reported; after
// that every byte is taken and dropped until reset.
// Configuration is written on cfg, one register per transfer, index in the
// order chrom_length, chrom_name, pos_begin, pos_end, lines_per_part,
// megabytes_per_part; cfg is always ready and should be written while idle.
// Throughput is one byte per cycle while the queue has room. A result is
// presented on result_out after the transfer of the byte that ends its line:
// the event is written into the queue at that transfer and moves into the
// output register when the back pops it. A stall on result_out fills the
// four-entry queue, after which byte_in drops ready until the receiver resumes.
// Reset (rst, synchronous) restores the register defaults and empties the
// queue; it needs no clearing pass.
module vcf_record_range_filter_splitter_core #(
  parameter int MAX_NAME_BYTES   = 8,
  parameter int LINE_LENGTH_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  vrrf_in_if.sink    byte_in,
  vrrf_out_if.source result_out,
  vrrf_cfg_if.sink   cfg
);
  localparam int EV_BITS = $bits(vrrf_pkg::ev_t);
  localparam int Q_WIDTH = EV_BITS + LINE_LENGTH_BITS;

  vrrf_pkg::cfg_t              regs;
  logic                        q_full;
  logic                        q_push;
  vrrf_pkg::ev_t               push_ev;
  logic [LINE_LENGTH_BITS-1:0] push_len;
  logic                        q_pop;
  logic                        q_not_empty;
  logic [Q_WIDTH-1:0]          q_data;
  vrrf_pkg::ev_t               q_ev;
  logic [LINE_LENGTH_BITS-1:0] q_len;

  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.chrom_length       <= '0;
      regs.chrom_name         <= '0;
      regs.pos_begin          <= 64'd1;
      regs.pos_end            <= '1;
      regs.lines_per_part     <= 31'd1000000;
      regs.megabytes_per_part <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        vrrf_pkg::REG_CHROM_LENGTH: regs.chrom_length       <= cfg.data[3:0];
        vrrf_pkg::REG_CHROM_NAME:   regs.chrom_name         <= cfg.data;
        vrrf_pkg::REG_POS_BEGIN:    regs.pos_begin          <= cfg.data;
        vrrf_pkg::REG_POS_END:      regs.pos_end            <= cfg.data;
        vrrf_pkg::REG_LINES_PART:   regs.lines_per_part     <= cfg.data[30:0];
        vrrf_pkg::REG_MB_PART:      regs.megabytes_per_part <= cfg.data[30:0];
        default: begin
        end
      endcase
    end
  end

  vrrf_front #(
    .MAX_NAME_BYTES   (MAX_NAME_BYTES),
    .LINE_LENGTH_BITS (LINE_LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .text_byte  (byte_in.text_byte),
    .stream_end (byte_in.stream_end),
    .q_full     (q_full),
    .push       (q_push),
    .push_ev    (push_ev),
    .push_len   (push_len)
  );

  vrrf_fifo #(
    .WIDTH (Q_WIDTH),
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_len, push_ev}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign q_ev  = vrrf_pkg::ev_t'(q_data[EV_BITS-1:0]);
  assign q_len = q_data[Q_WIDTH-1:EV_BITS];

  vrrf_back #(
    .LINE_LENGTH_BITS (LINE_LENGTH_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .q_not_empty (q_not_empty),
    .q_ev        (q_ev),
    .q_len       (q_len),
    .pop         (q_pop),
    .result_out  (result_out)
  );
endmodule

### sv/vrrf_fifo.sv
// Short event queue between the front and the back.
// Depends on nothing but its parameters.
module vrrf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

### sv/vrrf_front.sv
// Front of the splitter: parses bytes, tracks the header and the filter fields.
// Emits one event per finished line or stream end. Depends on vrrf_pkg.
module vrrf_front #(
  parameter int MAX_NAME_BYTES   = 8,
  parameter int LINE_LENGTH_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vrrf_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  text_byte,
  input  logic                        stream_end,
  input  logic                        q_full,
  output logic                        push,
  output vrrf_pkg::ev_t               push_ev,
  output logic [LINE_LENGTH_BITS-1:0] push_len
);
  localparam logic [LINE_LENGTH_BITS-1:0] LMAX = '1;

  logic                        in_header;
  logic                        halted;
  logic [LINE_LENGTH_BITS-1:0] line_bytes;
  logic [1:0]                  field_index;
  logic                        name_matches;
  logic [63:0]                 position_value;
  logic                        position_done;
  logic                        position_overflow;
  logic                        position_nonempty;

  logic                        accept;
  logic                        keep;
  logic                        hdr_next;
  logic [7:0]                  name_byte;
  logic [3:0]                  digit;
  logic [63:0]                 pos_times_ten;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push_len = line_bytes;

  // Filter decision for the line that is pending.
  always_comb begin
    if (cfg.chrom_length == '0) begin
      keep = 1'b1;
    end else if (32'(cfg.chrom_length) > 32'(MAX_NAME_BYTES)) begin
      keep = 1'b0;
    end else begin
      keep = name_matches && (field_index == 2'd2) && position_nonempty &&
             !position_overflow && (position_value >= cfg.pos_begin) &&
             (position_value <= cfg.pos_end);
    end
  end

  // Event formed for the current byte.
  always_comb begin
    push            = 1'b0;
    push_ev.kind    = vrrf_pkg::EV_DATA;
    push_ev.keep    = keep;
    push_ev.at_end  = 1'b0;
    if (accept && !halted) begin
      if (stream_end) begin
        push           = 1'b1;
        push_ev.at_end = 1'b1;
        if (in_header) begin
          push_ev.kind = vrrf_pkg::EV_END_HDR;
        end else if (line_bytes != '0) begin
          push_ev.kind = vrrf_pkg::EV_DATA;
        end else begin
          push_ev.kind = vrrf_pkg::EV_END;
        end
      end else if (text_byte == vrrf_pkg::CH_NEWLINE) begin
        push = 1'b1;
        if (in_header && line_bytes != '0) begin
          push_ev.kind = vrrf_pkg::EV_HEADER;
        end
      end
    end
  end

  // Name byte and decimal step for the data byte path.
  assign name_byte     = cfg.chrom_name[8*line_bytes[2:0] +: 8];
  assign digit         = 4'(text_byte - vrrf_pkg::CH_ZERO);
  assign pos_times_ten = (position_value << 3) + (position_value << 1) + 64'(digit);
  assign hdr_next      = in_header && !(line_bytes == '0 &&
                                        text_byte != vrrf_pkg::CH_HASH);

  // Line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header         <= 1'b1;
      halted            <= 1'b0;
      line_bytes        <= '0;
      field_index       <= '0;
      name_matches      <= 1'b1;
      position_value    <= '0;
      position_done     <= 1'b0;
      position_overflow <= 1'b0;
      position_nonempty <= 1'b0;
    end else if (accept && !halted) begin
      if (stream_end || text_byte == vrrf_pkg::CH_NEWLINE) begin
        if (stream_end) begin
          halted <= 1'b1;
        end else if (in_header && line_bytes == '0) begin
          in_header <= 1'b0;
        end
        line_bytes        <= '0;
        field_index       <= '0;
        name_matches      <= 1'b1;
        position_value    <= '0;
        position_done     <= 1'b0;
        position_overflow <= 1'b0;
        position_nonempty <= 1'b0;
      end else begin
        in_header <= hdr_next;
        if (!hdr_next) begin
          case (field_index)
            2'd0: begin
              if (text_byte == vrrf_pkg::CH_TAB) begin
                if (line_bytes != LINE_LENGTH_BITS'(cfg.chrom_length)) begin
                  name_matches <= 1'b0;
                end
                field_index <= 2'd1;
              end else if (line_bytes >= LINE_LENGTH_BITS'(cfg.chrom_length) ||
                           line_bytes >= LINE_LENGTH_BITS'(MAX_NAME_BYTES) ||
                           name_byte != text_byte) begin
                name_matches <= 1'b0;
              end
            end
            2'd1: begin
              if (text_byte == vrrf_pkg::CH_TAB) begin
                field_index <= 2'd2;
              end else begin
                position_nonempty <= 1'b1;
                if (!position_done) begin
                  if (text_byte >= vrrf_pkg::CH_ZERO && text_byte <= vrrf_pkg::CH_NINE) begin
                    if (position_value > vrrf_pkg::POS_TENTH ||
                        (position_value == vrrf_pkg::POS_TENTH && digit > 4'd5)) begin
                      position_overflow <= 1'b1;
                    end
                    position_value <= pos_times_ten;
                  end else begin
                    position_done <= 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (line_bytes != LMAX) begin
          line_bytes <= line_bytes + 1'b1;
        end
      end
    end
  end
endmodule

### sv/vrrf_back.sv
// Back of the splitter: part accounting and the registered result stage.
// Takes events from the queue. Depends on vrrf_pkg.
module vrrf_back #(
  parameter int LINE_LENGTH_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vrrf_pkg::cfg_t              cfg,
  input  logic                        q_not_empty,
  input  vrrf_pkg::ev_t               q_ev,
  input  logic [LINE_LENGTH_BITS-1:0] q_len,
  output logic                        pop,
  vrrf_out_if.source                  result_out
);
  localparam logic [30:0] MAX31 = '1;
  localparam logic [31:0] MAX32 = '1;
  localparam logic [52:0] MAX52 = 53'(52'hF_FFFF_FFFF_FFFF);

  logic [30:0] part_lines;
  logic [51:0] part_bytes;
  logic [31:0] part_counter;

  logic [30:0] lines_inc;
  logic [52:0] byte_sum;
  logic [51:0] bytes_inc;
  logic [30:0] limit;
  logic        full;
  logic        emit;
  logic        close;
  logic [2:0]  kind;
  logic [31:0] len32;
  logic [31:0] num;
  logic        last;
  logic [30:0] lt;
  logic [51:0] bt;

  assign pop = q_not_empty && (!result_out.valid || result_out.ready);

  // Candidate part totals for a kept line.
  assign lines_inc = (part_lines != MAX31) ? part_lines + 1'b1 : part_lines;
  assign byte_sum  = 53'(part_bytes) + 53'(q_len) + 53'd1;
  assign bytes_inc = (byte_sum > MAX52) ? 52'(MAX52) : byte_sum[51:0];
  assign limit     = (cfg.lines_per_part == '0) ? 31'd1 : cfg.lines_per_part;
  assign full      = (cfg.megabytes_per_part != '0) ?
                     (bytes_inc >= (52'(cfg.megabytes_per_part) << vrrf_pkg::MIB_SHIFT)) :
                     (lines_inc >= limit);
  assign len32     = (64'(q_len) > 64'(MAX32)) ? MAX32 : 32'(q_len);

  // Result for the event at the head of the queue.
  always_comb begin
    emit  = 1'b1;
    close = 1'b0;
    kind  = vrrf_pkg::KIND_HEADER;
    num   = '0;
    last  = 1'b0;
    lt    = '0;
    bt    = '0;
    case (q_ev.kind)
      vrrf_pkg::EV_HEADER: begin
        kind = vrrf_pkg::KIND_HEADER;
      end
      vrrf_pkg::EV_END_HDR: begin
        kind = vrrf_pkg::KIND_END_HDR;
      end
      vrrf_pkg::EV_END: begin
        kind  = vrrf_pkg::KIND_CLOSE;
        emit  = (part_lines != '0);
        close = emit;
        num   = part_counter;
        last  = 1'b1;
        lt    = part_lines;
        bt    = part_bytes;
      end
      vrrf_pkg::EV_DATA: begin
        num = part_counter;
        if (q_ev.keep) begin
          kind  = vrrf_pkg::KIND_KEPT;
          last  = full || q_ev.at_end;
          lt    = lines_inc;
          bt    = bytes_inc;
        end else begin
          kind  = vrrf_pkg::KIND_SKIPPED;
          last  = q_ev.at_end && (part_lines != '0);
          lt    = part_lines;
          bt    = part_bytes;
        end
        close = last;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Part counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      part_lines   <= '0;
      part_bytes   <= '0;
      part_counter <= '0;
    end else if (pop) begin
      if (close) begin
        part_lines <= '0;
        part_bytes <= '0;
        if (part_counter != MAX32) begin
          part_counter <= part_counter + 1'b1;
        end
      end else if (q_ev.kind == vrrf_pkg::EV_DATA && q_ev.keep) begin
        part_lines <= lines_inc;
        part_bytes <= bytes_inc;
      end
    end
  end

  // Result register, refilled while the previous result is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (pop) begin
      result_out.valid <= emit;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_out.line_kind       <= kind;
      result_out.line_length     <= (q_ev.kind == vrrf_pkg::EV_HEADER ||
                                     q_ev.kind == vrrf_pkg::EV_DATA) ? len32 : '0;
      result_out.part_number     <= num;
      result_out.part_last       <= last;
      result_out.part_line_total <= lt;
      result_out.part_byte_total <= bt;
    end
  end
endmodule
